### hdl/hvn_pkg.sv
// Package for the heightmap vertex normal block: widths, triangle tables and helpers.
// Used by hvn_norm and heightmap_vertex_normal; depends on nothing else.
package hvn_pkg;

   localparam int H_W    = 16;          // elevation width, Q8.8
   localparam int SP_W   = 16;          // grid spacing width, Q8.8
   localparam int EV_W   = 17;          // edge vector component width
   localparam int PR_W   = 2 * EV_W;    // product of two components
   localparam int CR_W   = PR_W + 1;    // cross product component
   localparam int LANES  = 8;
   localparam int ODD_N  = 4;
   localparam int OUT_W  = 16;

   // Configuration register indexes.
   localparam logic [0:0] REG_X_SPACING = 1'b0;
   localparam logic [0:0] REG_Z_SPACING = 1'b1;

   // Normaliser internals: magnitudes are brought to MAG_W bits with the top bit at MSB_POS.
   localparam int MAG_W   = 30;
   localparam int MSB_POS = MAG_W - 1;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int L2_W    = SQ_W + 2;
   localparam int SQ_N    = L2_W / 2;
   localparam int LEN_W   = MAG_W + 1;

   localparam logic [3:0] BIT_W = 4'b0001;
   localparam logic [3:0] BIT_E = 4'b0010;
   localparam logic [3:0] BIT_N = 4'b0100;
   localparam logic [3:0] BIT_S = 4'b1000;

   // Neighbour offsets of each triangle: a(dx,dy), b(dx,dy); the normal is a x b.
   localparam int EVEN_OFF [LANES][4] = '{
      '{-1, -1,  0, -1}, '{-1,  0, -1, -1},
      '{-1,  1, -1,  0}, '{ 0,  1, -1,  1},
      '{ 1, -1,  1,  0}, '{ 0, -1,  1, -1},
      '{ 1,  0,  1,  1}, '{ 1,  1,  0,  1}};
   localparam logic [3:0] EVEN_NEED [LANES] = '{
      BIT_W | BIT_N, BIT_W | BIT_N, BIT_W | BIT_S, BIT_W | BIT_S,
      BIT_E | BIT_N, BIT_E | BIT_N, BIT_E | BIT_S, BIT_E | BIT_S};
   localparam int ODD_OFF [ODD_N][4] = '{
      '{-1,  0,  0, -1}, '{ 0,  1, -1,  0},
      '{ 0, -1,  1,  0}, '{ 1,  0,  0,  1}};
   localparam logic [3:0] ODD_NEED [ODD_N] = '{
      BIT_W | BIT_N, BIT_W | BIT_S, BIT_E | BIT_N, BIT_E | BIT_S};

   // Place of a neighbour in the row-major 3x3 neighbourhood.
   function automatic logic [3:0] hvn_idx(input int dx, input int dy);
      return 4'((dy + 1) * 3 + (dx + 1));
   endfunction

   // Offset of -1, 0 or +1 times a spacing.
   function automatic logic signed [EV_W-1:0] hvn_span(input int d, input logic [SP_W-1:0] s);
      logic signed [EV_W-1:0] v;
      v = $signed({1'b0, s});
      if (d > 0) return v;
      else if (d < 0) return -v;
      else return '0;
   endfunction

   function automatic int hvn_norm_lat(input int frac);
      return frac + 39;
   endfunction

endpackage

### hdl/hvn_req_if.sv
// Input channel of the heightmap vertex normal block: one vertex neighbourhood a word.
// Depends on nothing.
interface hvn_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] h_center;
   logic signed [15:0] h_north;
   logic signed [15:0] h_south;
   logic signed [15:0] h_west;
   logic signed [15:0] h_east;
   logic signed [15:0] h_northwest;
   logic signed [15:0] h_northeast;
   logic signed [15:0] h_southwest;
   logic signed [15:0] h_southeast;
   logic               even_vertex;
   logic [3:0]         edge_mask;

   modport source (output valid, h_center, h_north, h_south, h_west, h_east, h_northwest,
                   h_northeast, h_southwest, h_southeast, even_vertex, edge_mask,
                   input ready);
   modport sink (input valid, h_center, h_north, h_south, h_west, h_east, h_northwest,
                 h_northeast, h_southwest, h_southeast, even_vertex, edge_mask,
                 output ready);
endinterface

### hdl/hvn_rsp_if.sv
// Result channel of the heightmap vertex normal block: one unit normal a word.
// Depends on nothing.
interface hvn_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] normal_x;
   logic signed [15:0] normal_y;
   logic signed [15:0] normal_z;

   modport source (output valid, normal_x, normal_y, normal_z, input ready);
   modport sink (input valid, normal_x, normal_y, normal_z, output ready);
endinterface

### hdl/hvn_norm.sv
// Pipelined vector normaliser: scale, sum of squares, square root and three dividers.
// Depends on hvn_pkg. The pipeline advances only when en is high.
module hvn_norm #(
   parameter int IN_W      = 35,
   parameter int FRAC_BITS = 14
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic signed [IN_W-1:0]     vec_in  [3],
   output logic signed [FRAC_BITS+1:0] nrm_out [3]
);
   import hvn_pkg::*;

   localparam int PW    = $clog2(IN_W);
   localparam int DIV_N = FRAC_BITS + 1;
   localparam int RW    = MAG_W + 2 + FRAC_BITS;

   logic [IN_W-1:0]    mag1_ff [3], mag1_in [3];
   logic [2:0]         neg1_ff, neg1_in;
   logic [IN_W-1:0]    max1_ff, max1_in;
   logic [IN_W-1:0]    mag2_ff [3];
   logic [2:0]         neg2_ff;
   logic               zero2_ff, zero2_in;
   logic [PW-1:0]      p2_ff, p2_in;
   logic [MAG_W-1:0]   mag3_ff [3], mag3_in [3];
   logic [2:0]         neg3_ff;
   logic               zero3_ff;
   logic [SQ_W-1:0]    sq4_ff [3], sq4_in [3];
   logic [MAG_W-1:0]   mag4_ff [3];
   logic [2:0]         neg4_ff;
   logic               zero4_ff;

   logic [L2_W-1:0]    sq_v_ff [SQ_N+1], sq_v_in [SQ_N+1];
   logic [L2_W:0]      sq_r_ff [SQ_N+1], sq_r_in [SQ_N+1];
   logic [MAG_W-1:0]   sd_mag_ff [SQ_N+1][3], sd_mag_in [SQ_N+1][3];
   logic [2:0]         sd_neg_ff [SQ_N+1], sd_neg_in [SQ_N+1];
   logic               sd_zero_ff [SQ_N+1], sd_zero_in [SQ_N+1];

   logic [LEN_W-1:0]   dv_len_ff [DIV_N+1], dv_len_in [DIV_N+1];
   logic [RW-1:0]      dv_rem_ff [DIV_N+1][3], dv_rem_in [DIV_N+1][3];
   logic [DIV_N-1:0]   dv_q_ff [DIV_N+1][3], dv_q_in [DIV_N+1][3];
   logic [2:0]         dv_neg_ff [DIV_N+1], dv_neg_in [DIV_N+1];
   logic               dv_zero_ff [DIV_N+1], dv_zero_in [DIV_N+1];

   logic signed [FRAC_BITS+1:0] nrm_ff [3], nrm_in [3];

   // Magnitudes, signs and the leading one.
   always_comb begin
      max1_in = '0;
      for (int i = 0; i < 3; i++) begin
         neg1_in[i] = vec_in[i][IN_W-1];
         mag1_in[i] = neg1_in[i] ? IN_W'(-vec_in[i]) : IN_W'(vec_in[i]);
         max1_in    = max1_in | mag1_in[i];
      end
      p2_in = '0;
      for (int b = 0; b < IN_W; b++) begin
         if (max1_ff[b]) p2_in = PW'(b);
      end
      zero2_in = (max1_ff == '0);
   end

   // Shifting by the leading one puts the top bit at MSB_POS, truncating on the right.
   always_comb begin
      logic [IN_W+MSB_POS-1:0] wide;
      for (int i = 0; i < 3; i++) begin
         wide       = {mag2_ff[i], {MSB_POS{1'b0}}} >> p2_ff;
         mag3_in[i] = wide[MAG_W-1:0];
         sq4_in[i]  = SQ_W'(mag3_ff[i]) * SQ_W'(mag3_ff[i]);
      end
   end

   // Square root, one result bit a stage.
   always_comb begin
      logic [L2_W:0] bitv, trial;
      sq_v_in[0]   = L2_W'(sq4_ff[0]) + L2_W'(sq4_ff[1]) + L2_W'(sq4_ff[2]);
      sq_r_in[0]   = '0;
      sd_mag_in[0] = mag4_ff;
      sd_neg_in[0] = neg4_ff;
      sd_zero_in[0] = zero4_ff;
      for (int t = 0; t < SQ_N; t++) begin
         bitv  = (L2_W+1)'(1) << (2 * (SQ_N - 1 - t));
         trial = sq_r_ff[t] + bitv;
         if ({1'b0, sq_v_ff[t]} >= trial) begin
            sq_v_in[t+1] = sq_v_ff[t] - trial[L2_W-1:0];
            sq_r_in[t+1] = (sq_r_ff[t] >> 1) + bitv;
         end else begin
            sq_v_in[t+1] = sq_v_ff[t];
            sq_r_in[t+1] = sq_r_ff[t] >> 1;
         end
         sd_mag_in[t+1]  = sd_mag_ff[t];
         sd_neg_in[t+1]  = sd_neg_ff[t];
         sd_zero_in[t+1] = sd_zero_ff[t];
      end
   end

   // Rounded division of each magnitude by the length, one quotient bit a stage.
   always_comb begin
      logic [LEN_W-1:0] len;
      logic [RW-1:0]    dsr;
      len = sq_r_ff[SQ_N][LEN_W-1:0];
      dv_len_in[0]  = len;
      dv_neg_in[0]  = sd_neg_ff[SQ_N];
      dv_zero_in[0] = sd_zero_ff[SQ_N];
      for (int i = 0; i < 3; i++) begin
         dv_rem_in[0][i] = (RW'(sd_mag_ff[SQ_N][i]) << FRAC_BITS) + RW'(len >> 1);
         dv_q_in[0][i]   = '0;
      end
      for (int t = 0; t < DIV_N; t++) begin
         dsr = RW'(dv_len_ff[t]) << (DIV_N - 1 - t);
         for (int i = 0; i < 3; i++) begin
            if (dv_rem_ff[t][i] >= dsr) begin
               dv_rem_in[t+1][i] = dv_rem_ff[t][i] - dsr;
               dv_q_in[t+1][i]   = {dv_q_ff[t][i][DIV_N-2:0], 1'b1};
            end else begin
               dv_rem_in[t+1][i] = dv_rem_ff[t][i];
               dv_q_in[t+1][i]   = {dv_q_ff[t][i][DIV_N-2:0], 1'b0};
            end
         end
         dv_len_in[t+1]  = dv_len_ff[t];
         dv_neg_in[t+1]  = dv_neg_ff[t];
         dv_zero_in[t+1] = dv_zero_ff[t];
      end
   end

   // Clamp to one, restore the sign; a zero vector gives a zero normal.
   always_comb begin
      logic [DIV_N-1:0] q;
      logic [DIV_N-1:0] one;
      one = DIV_N'(1) << FRAC_BITS;
      for (int i = 0; i < 3; i++) begin
         q = dv_q_ff[DIV_N][i];
         if (q > one) q = one;
         if (dv_zero_ff[DIV_N]) nrm_in[i] = '0;
         else if (dv_neg_ff[DIV_N][i]) nrm_in[i] = -$signed({1'b0, q});
         else nrm_in[i] = $signed({1'b0, q});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag1_ff    <= mag1_in;
         neg1_ff    <= neg1_in;
         max1_ff    <= max1_in;
         mag2_ff    <= mag1_ff;
         neg2_ff    <= neg1_ff;
         zero2_ff   <= zero2_in;
         p2_ff      <= p2_in;
         mag3_ff    <= mag3_in;
         neg3_ff    <= neg2_ff;
         zero3_ff   <= zero2_ff;
         sq4_ff     <= sq4_in;
         mag4_ff    <= mag3_ff;
         neg4_ff    <= neg3_ff;
         zero4_ff   <= zero3_ff;
         sq_v_ff    <= sq_v_in;
         sq_r_ff    <= sq_r_in;
         sd_mag_ff  <= sd_mag_in;
         sd_neg_ff  <= sd_neg_in;
         sd_zero_ff <= sd_zero_in;
         dv_len_ff  <= dv_len_in;
         dv_rem_ff  <= dv_rem_in;
         dv_q_ff    <= dv_q_in;
         dv_neg_ff  <= dv_neg_in;
         dv_zero_ff <= dv_zero_in;
         nrm_ff     <= nrm_in;
      end
   end

   assign nrm_out = nrm_ff;

endmodule

### hdl/heightmap_vertex_normal.sv
// Heightmap vertex normal: each word passes through two normaliser pipelines in turn,
// whose square root and division take one bit a stage.
// Throughput one word per cycle; a stall on the result side holds the whole pipeline.
// Synchronous active-high reset empties the pipeline and sets both spacings to 256.
// Depends on hvn_pkg, hvn_req_if, hvn_rsp_if and hvn_norm.
module heightmap_vertex_normal #(
   parameter int FRAC_BITS = 14
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [0:0]                  csr_index,
   input  logic [hvn_pkg::SP_W-1:0]    csr_wdata,
   hvn_req_if.sink                     req_chan,
   hvn_rsp_if.source                   rsp_chan
);
   import hvn_pkg::*;

   localparam int NL   = hvn_norm_lat(FRAC_BITS);
   localparam int NW   = FRAC_BITS + 2;
   localparam int SM_W = FRAC_BITS + 5;
   localparam int TOT  = 2 * NL + 4;

   logic [SP_W-1:0]        xs_ff, zs_ff;
   logic [TOT-1:0]         vld_ff;
   logic                   en;
   logic signed [H_W-1:0]  h9 [9];

   logic signed [EV_W-1:0] a_ff [LANES][3], a_in [LANES][3];
   logic signed [EV_W-1:0] b_ff [LANES][3], b_in [LANES][3];
   logic [LANES-1:0]       on_a_ff, on_a_in, on_b_ff;
   logic signed [PR_W-1:0] p_ff [LANES][6], p_in [LANES][6];
   logic signed [CR_W-1:0] c_ff [LANES][3], c_in [LANES][3];
   logic signed [NW-1:0]   ln_nrm [LANES][3];
   logic signed [SM_W-1:0] sm_ff [3], sm_in [3];
   logic signed [NW-1:0]   fin [3];
   logic signed [OUT_W-1:0] sat [3];

   assign en             = !vld_ff[TOT-1] || rsp_chan.ready;
   assign req_chan.ready = en;
   assign rsp_chan.valid = vld_ff[TOT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         xs_ff  <= SP_W'(256);
         zs_ff  <= SP_W'(256);
         vld_ff <= '0;
      end else begin
         if (csr_we && csr_index == REG_X_SPACING) xs_ff <= csr_wdata;
         if (csr_we && csr_index == REG_Z_SPACING) zs_ff <= csr_wdata;
         if (en) vld_ff <= {vld_ff[TOT-2:0], req_chan.valid};
      end
   end

   // Edge vectors of every triangle; odd vertices use the first four lanes only.
   always_comb begin
      int off [4];
      logic [3:0] need;
      logic       use_lane;
      h9[0] = req_chan.h_northwest;
      h9[1] = req_chan.h_north;
      h9[2] = req_chan.h_northeast;
      h9[3] = req_chan.h_west;
      h9[4] = req_chan.h_center;
      h9[5] = req_chan.h_east;
      h9[6] = req_chan.h_southwest;
      h9[7] = req_chan.h_south;
      h9[8] = req_chan.h_southeast;
      for (int j = 0; j < LANES; j++) begin
         if (req_chan.even_vertex) begin
            off      = EVEN_OFF[j];
            need     = EVEN_NEED[j];
            use_lane = 1'b1;
         end else if (j < ODD_N) begin
            off      = ODD_OFF[j];
            need     = ODD_NEED[j];
            use_lane = 1'b1;
         end else begin
            off      = '{0, 0, 0, 0};
            need     = '1;
            use_lane = 1'b0;
         end
         on_a_in[j] = use_lane && ((req_chan.edge_mask & need) == need);
         a_in[j][0] = hvn_span(off[0], xs_ff);
         a_in[j][1] = EV_W'(h9[hvn_idx(off[0], off[1])]) - EV_W'(req_chan.h_center);
         a_in[j][2] = hvn_span(-off[1], zs_ff);
         b_in[j][0] = hvn_span(off[2], xs_ff);
         b_in[j][1] = EV_W'(h9[hvn_idx(off[2], off[3])]) - EV_W'(req_chan.h_center);
         b_in[j][2] = hvn_span(-off[3], zs_ff);
      end
   end

   // Cross products: products in one stage, differences in the next.
   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         p_in[j][0] = a_ff[j][1] * b_ff[j][2];
         p_in[j][1] = a_ff[j][2] * b_ff[j][1];
         p_in[j][2] = a_ff[j][2] * b_ff[j][0];
         p_in[j][3] = a_ff[j][0] * b_ff[j][2];
         p_in[j][4] = a_ff[j][0] * b_ff[j][1];
         p_in[j][5] = a_ff[j][1] * b_ff[j][0];
         for (int i = 0; i < 3; i++) begin
            if (on_b_ff[j]) c_in[j][i] = CR_W'(p_ff[j][2*i]) - CR_W'(p_ff[j][2*i+1]);
            else c_in[j][i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         on_a_ff <= on_a_in;
         p_ff    <= p_in;
         on_b_ff <= on_a_ff;
         c_ff    <= c_in;
         sm_ff   <= sm_in;
      end
   end

   // A skipped triangle enters its lane as a zero vector and leaves as a zero normal.
   for (genvar j = 0; j < LANES; j++) begin : g_lane
      hvn_norm #(.IN_W(CR_W), .FRAC_BITS(FRAC_BITS)) u_tri_norm (
         .clock   (clock),
         .en      (en),
         .vec_in  (c_ff[j]),
         .nrm_out (ln_nrm[j])
      );
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sm_in[i] = '0;
         for (int j = 0; j < LANES; j++) sm_in[i] = sm_in[i] + SM_W'(ln_nrm[j][i]);
      end
   end

   hvn_norm #(.IN_W(SM_W), .FRAC_BITS(FRAC_BITS)) u_sum_norm (
      .clock   (clock),
      .en      (en),
      .vec_in  (sm_ff),
      .nrm_out (fin)
   );

   // Saturation only bites when FRAC_BITS is above 14.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (int'(fin[i]) > 32767) sat[i] = 16'sh7fff;
         else if (int'(fin[i]) < -32768) sat[i] = -16'sh8000;
         else sat[i] = OUT_W'(fin[i]);
      end
   end

   assign rsp_chan.normal_x = sat[0];
   assign rsp_chan.normal_y = sat[1];
   assign rsp_chan.normal_z = sat[2];

   a_rsp_from_pipe: assert property (@(posedge clock) disable iff (reset)
      $rose(vld_ff[TOT-1]) |-> $past(vld_ff[TOT-2]))
      else $error("result word appeared without an item in the stage before");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved while the result was stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> vld_ff == '0)
      else $error("pipeline not empty after reset");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[TOT-1] |-> (int'(fin[0]) <= (1 << FRAC_BITS) && int'(fin[0]) >= -(1 << FRAC_BITS)
                      && int'(fin[1]) <= (1 << FRAC_BITS) && int'(fin[1]) >= -(1 << FRAC_BITS)
                      && int'(fin[2]) <= (1 << FRAC_BITS) && int'(fin[2]) >= -(1 << FRAC_BITS)))
      else $error("normal component outside the unit range");

endmodule
